/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands used by the bracket stack engine RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, held off while in reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* hdl/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg
// Types and constants for the balanced bracket checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbc_pkg;

    localparam int POS_W  = 25;
    localparam int EPOS_W = 24;

    // Longest text that is counted; a byte at this index or later is an error.
    localparam logic [POS_W-1:0] MAX_TEXT_BYTES = 25'd16777216;

    localparam logic [7:0] CHAR_ROUND_OPEN   = 8'h28;
    localparam logic [7:0] CHAR_ROUND_CLOSE  = 8'h29;
    localparam logic [7:0] CHAR_SQUARE_OPEN  = 8'h5B;
    localparam logic [7:0] CHAR_SQUARE_CLOSE = 8'h5D;
    localparam logic [7:0] CHAR_CURLY_OPEN   = 8'h7B;
    localparam logic [7:0] CHAR_CURLY_CLOSE  = 8'h7D;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_BAD_CLOSE = 3'd1,
        VERDICT_UNCLOSED  = 3'd2,
        VERDICT_OVERFLOW  = 3'd3,
        VERDICT_TOO_LONG  = 3'd4
    } verdict_t;

    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        verdict_t         verdict;
        logic [POS_W-1:0] position;
    } out_item_t;

    // Classified byte handed from the front end to the stack engine.
    typedef struct packed {
        logic [POS_W-1:0] position;
        kind_t            open_kind;
        kind_t            close_kind;
        logic             final_byte;
    } work_item_t;

    typedef struct packed {
        logic [EPOS_W-1:0] position;
        kind_t             kind;
    } stack_entry_t;

endpackage

/* hdl/bbc_queue.sv */
// ----------------------------------------------------------------------------
// bbc_queue
// Small FIFO of classified bytes between the front end and the stack engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bbc_pkg::work_item_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                q_valid,
    output bbc_pkg::work_item_t q_item
);
    import bbc_pkg::*;

    work_item_t              entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW:0]       wr_ptr_reg;
    logic [QUEUE_AW:0]       wr_ptr_next;
    logic [QUEUE_AW:0]       rd_ptr_reg;
    logic [QUEUE_AW:0]       rd_ptr_next;
    logic                    empty;

    assign empty = (wr_ptr_reg == rd_ptr_reg);
    assign full  = (wr_ptr_reg[QUEUE_AW-1:0] == rd_ptr_reg[QUEUE_AW-1:0])
                && (wr_ptr_reg[QUEUE_AW] != rd_ptr_reg[QUEUE_AW]);

    assign q_valid = !empty;
    assign q_item  = entry_reg[rd_ptr_reg[QUEUE_AW-1:0]];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg[QUEUE_AW-1:0]] <= push_item;
        end
    end

endmodule

/* hdl/bbc_front.sv */
// ----------------------------------------------------------------------------
// bbc_front
// Takes text bytes, numbers them and sorts brackets into open/close kinds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  bbc_pkg::in_item_t   item,
    input  logic                q_full,
    output logic                q_push,
    output bbc_pkg::work_item_t q_item
);
    import bbc_pkg::*;

    logic [POS_W-1:0] index_reg;
    logic [POS_W-1:0] index_next;
    kind_t            open_kind;
    kind_t            close_kind;

    assign item_ready = !q_full;
    assign q_push     = item_valid && item_ready;

    always_comb
    begin
        unique case (item.text_byte)
            CHAR_ROUND_OPEN:  open_kind = KIND_ROUND;
            CHAR_SQUARE_OPEN: open_kind = KIND_SQUARE;
            CHAR_CURLY_OPEN:  open_kind = KIND_CURLY;
            default:          open_kind = KIND_NONE;
        endcase
        unique case (item.text_byte)
            CHAR_ROUND_CLOSE:  close_kind = KIND_ROUND;
            CHAR_SQUARE_CLOSE: close_kind = KIND_SQUARE;
            CHAR_CURLY_CLOSE:  close_kind = KIND_CURLY;
            default:           close_kind = KIND_NONE;
        endcase
    end

    always_comb
    begin
        q_item.position   = index_reg;
        q_item.open_kind  = open_kind;
        q_item.close_kind = close_kind;
        q_item.final_byte = item.final_byte;
    end

    // Index restarts after the final byte and saturates at the length limit.
    always_comb
    begin
        index_next = index_reg;
        if (q_push)
        begin
            priority if (item.final_byte)
                index_next = '0;
            else if (index_reg < MAX_TEXT_BYTES)
                index_next = index_reg + 1'b1;
            else
                index_next = index_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
        end
        else
        begin
            index_reg <= index_next;
        end
    end

endmodule

/* hdl/bbc_back.sv */
// ----------------------------------------------------------------------------
// bbc_back
// Stack engine: one push or pop per cycle unless stalled; verdict register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_back #(
    parameter int STACK_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  bbc_pkg::work_item_t q_item,
    output logic                q_pop,
    output logic                result_valid,
    input  logic                result_ready,
    output bbc_pkg::out_item_t  result
);
    import bbc_pkg::*;

    `include "assert_macros.svh"

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [DW-1:0] FULL_DEPTH = DW'(STACK_DEPTH);

    stack_entry_t      stack_mem [STACK_DEPTH];

    logic [DW-1:0]     depth_reg;
    logic [DW-1:0]     depth_next;
    stack_entry_t      top_reg;
    stack_entry_t      top_next;
    stack_entry_t      below_reg;
    verdict_t          err_reg;
    verdict_t          err_next;
    logic [POS_W-1:0]  err_pos_reg;
    logic [POS_W-1:0]  err_pos_next;
    logic              result_valid_reg;
    logic              result_valid_next;
    out_item_t         result_reg;
    out_item_t         result_next;

    logic              push;
    stack_entry_t      new_entry;
    logic [AW-1:0]     rd_addr;
    logic [POS_W-1:0]  count;
    logic              slot_free;

    assign slot_free    = !result_valid_reg || result_ready;
    assign q_pop        = q_valid && (!q_item.final_byte || slot_free);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign new_entry.position = q_item.position[EPOS_W-1:0];
    assign new_entry.kind     = q_item.open_kind;

    assign count = (q_item.position >= MAX_TEXT_BYTES) ? MAX_TEXT_BYTES
                                                       : q_item.position + 1'b1;

    always_comb
    begin
        depth_next        = depth_reg;
        top_next          = top_reg;
        err_next          = err_reg;
        err_pos_next      = err_pos_reg;
        push              = 1'b0;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;

        if (q_pop)
        begin
            if (err_reg == VERDICT_OK)
            begin
                priority if (q_item.position >= MAX_TEXT_BYTES)
                begin
                    err_next     = VERDICT_TOO_LONG;
                    err_pos_next = MAX_TEXT_BYTES;
                end
                else if (q_item.open_kind != KIND_NONE)
                begin
                    if (depth_reg == FULL_DEPTH)
                    begin
                        err_next     = VERDICT_OVERFLOW;
                        err_pos_next = q_item.position;
                    end
                    else
                    begin
                        push       = 1'b1;
                        depth_next = depth_reg + 1'b1;
                        top_next   = new_entry;
                    end
                end
                else if (q_item.close_kind != KIND_NONE)
                begin
                    if (depth_reg == '0 || top_reg.kind != q_item.close_kind)
                    begin
                        err_next     = VERDICT_BAD_CLOSE;
                        err_pos_next = q_item.position;
                    end
                    else
                    begin
                        depth_next = depth_reg - 1'b1;
                        top_next   = below_reg;
                    end
                end
                else
                begin
                    // other bytes only advance the count
                    push = 1'b0;
                end
            end

            if (q_item.final_byte)
            begin
                result_valid_next = 1'b1;
                priority if (err_next != VERDICT_OK)
                begin
                    result_next.verdict  = err_next;
                    result_next.position = err_pos_next;
                end
                else if (depth_next != '0)
                begin
                    result_next.verdict  = VERDICT_UNCLOSED;
                    result_next.position = {1'b0, top_next.position};
                end
                else
                begin
                    result_next.verdict  = VERDICT_OK;
                    result_next.position = count;
                end
                depth_next   = '0;
                err_next     = VERDICT_OK;
                err_pos_next = '0;
            end
        end
    end

    // The entry just below the new top is fetched every cycle, so a pop
    // always finds its successor ready in below_reg.
    always_comb
    begin
        if (depth_next >= DW'(2))
            rd_addr = AW'(depth_next - DW'(2));
        else
            rd_addr = '0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[depth_reg[AW-1:0]] <= new_entry;
        end
        below_reg  <= stack_mem[rd_addr];
        top_reg    <= top_next;
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg        <= '0;
            err_reg          <= VERDICT_OK;
            err_pos_reg      <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg        <= depth_next;
            err_reg          <= err_next;
            err_pos_reg      <= err_pos_next;
            result_valid_reg <= result_valid_next;
        end
    end

    `ASSERT_NEVER(a_depth_bound, depth_reg > FULL_DEPTH, "stack depth beyond capacity")
    `ASSERT_NEVER(a_no_result_overrun, q_pop && q_item.final_byte && !slot_free, "verdict overwrites pending result")
    `ASSERT_CLK(a_clear_after_final, q_pop && q_item.final_byte |=> depth_reg == '0 && err_reg == VERDICT_OK, "text state not cleared after final byte")

endmodule

/* hdl/bracket_balance_checker_top.sv */
// ----------------------------------------------------------------------------
// bracket_balance_checker_top
// Streaming checker for balanced (), [] and {} brackets in a byte text.
// ----------------------------------------------------------------------------
// Takes one text byte per cycle, sustained while verdicts are taken, with
// final_byte marking the end of a text, and returns one verdict per text:
// balanced with the byte count, bad close, innermost unclosed open, stack
// overflow or too long, with the offending position. A verdict passes
// through the queue and the verdict register after its final byte is
// transferred. The figure of one byte per cycle is set by the bracket stack:
// its top entry sits in a register and the entry below it is prefetched from
// the stack memory every cycle, so any mix of pushes and pops runs at full
// rate. A four-entry queue separates the byte classifier from the stack, and
// the verdict register lets input keep flowing while a result waits. The
// stack memory needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bracket_balance_checker_top #(
    parameter int STACK_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  bbc_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output bbc_pkg::out_item_t result
);
    import bbc_pkg::*;

    logic       q_push;
    work_item_t q_push_item;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    work_item_t q_item;

    bbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_push_item)
    );

    bbc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    bbc_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule
